// File: src/base32_stream_decoder_unit_macros.svh
// Assertion macros used by the base32 stream decoder checker.
`ifndef BASE32_STREAM_DECODER_UNIT_MACROS_SVH
`define BASE32_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define B32D_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b32d checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is held.
`define B32D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b32d checker: next-cycle property failed");

`endif

// File: src/b32d_pkg.sv
// Shared types, constants and the symbol lookup of the base32 stream decoder.
package b32d_pkg;

    localparam int unsigned SYM_W           = 8;
    localparam int unsigned VAL_W           = 5;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned CNT_W           = 16;
    localparam int unsigned PEND_W          = 7;
    localparam int unsigned PCNT_W          = 3;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [CNT_W-1:0] MAX_BYTES_RESET = 16'hFFFF;
    localparam logic [SYM_W-1:0] SYM_NUL         = 8'h00;
    localparam logic [VAL_W-1:0] DIGIT_BASE      = 5'd26;

    // Classified character handed from the front to the back
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             nul;
        logic             last;
    } t_sym_item;

    // Map one character to its five-bit value; anything unknown is zero
    function automatic logic [VAL_W-1:0] sym_value(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] off;
        off = '0;
        unique case (c) inside
            [8'h61:8'h7A]: off = c - 8'h61;
            [8'h41:8'h5A]: off = c - 8'h41;
            [8'h30:8'h35]: off = c - 8'h30 + SYM_W'(DIGIT_BASE);
            default:       off = '0;
        endcase
        return off[VAL_W-1:0];
    endfunction

endpackage

// File: src/b32d_front.sv
// Front part: accepts characters, classifies them and pushes them into the queue.
module b32d_front (
    input  logic                      i_valid,
    input  logic [b32d_pkg::SYM_W-1:0] i_symbol,
    input  logic                      i_last,
    input  logic                      i_queue_full,
    output logic                      o_stall,
    output logic                      o_push,
    output b32d_pkg::t_sym_item       o_item
);
    import b32d_pkg::*;

    // Hold the input side off while the queue has no room
    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // Classify the character
    always_comb begin
        o_item.value = sym_value(i_symbol);
        o_item.nul   = (i_symbol == SYM_NUL);
        o_item.last  = i_last;
    end
endmodule

// File: src/b32d_queue.sv
// Short queue between the front and the back parts.
module b32d_queue #(
    parameter int unsigned DEPTH = b32d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b32d_pkg::t_sym_item i_item,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output b32d_pkg::t_sym_item o_item
);
    import b32d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned OCC_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    t_sym_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [OCC_W-1:0] r_occ, n_occ;

    assign o_full  = (r_occ == OCC_FULL);
    assign o_valid = (r_occ != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_occ    = r_occ;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_occ = r_occ + 1'b1;
        end else if (!i_push && i_pop) begin
            n_occ = r_occ - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_occ    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_occ    <= n_occ;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end
endmodule

// File: src/b32d_back.sv
// Back part: runs the bit accumulator, applies the byte limit and registers results.
module b32d_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [b32d_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                        i_item_valid,
    input  b32d_pkg::t_sym_item         i_item,
    output logic                        o_pop,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [b32d_pkg::BYTE_W-1:0] o_data,
    output logic                        o_data_valid,
    output logic                        o_done_res,
    output logic [b32d_pkg::CNT_W-1:0]  o_byte_count
);
    import b32d_pkg::*;

    logic [CNT_W-1:0]  r_max_bytes;
    logic [PEND_W-1:0] r_pend_bits, n_pend_bits;
    logic [PCNT_W-1:0] r_pend_cnt, n_pend_cnt;
    logic [CNT_W-1:0]  r_emit_cnt, n_emit_cnt;
    logic              r_halted, n_halted;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_dvalid;
    logic              r_out_done;
    logic [CNT_W-1:0]  r_out_count;

    logic                    halt_now;
    logic [PEND_W+VAL_W-1:0] acc;
    logic [PCNT_W:0]         sum;
    logic [PCNT_W-1:0]       rem;
    logic                    have_byte;
    logic [BYTE_W-1:0]       byte_val;
    logic [PEND_W-1:0]       keep_mask;
    logic                    emit;
    logic                    has_result;

    // Take the next item whenever the output register frees up
    assign o_pop = i_item_valid && (!r_out_valid || !i_stall);

    // Decode one item against the accumulator
    always_comb begin
        halt_now  = r_halted || i_item.nul;
        acc       = {r_pend_bits, i_item.value};
        sum       = {1'b0, r_pend_cnt} + (PCNT_W+1)'(VAL_W);
        have_byte = sum[PCNT_W];
        rem       = sum[PCNT_W-1:0];
        byte_val  = BYTE_W'(acc >> rem);
        keep_mask = PEND_W'((8'd1 << rem) - 8'd1);
        emit      = !halt_now && have_byte && (r_emit_cnt < r_max_bytes);

        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        n_emit_cnt  = emit ? r_emit_cnt + 1'b1 : r_emit_cnt;
        n_halted    = halt_now;
        if (!halt_now) begin
            n_pend_bits = acc[PEND_W-1:0] & keep_mask;
            n_pend_cnt  = rem;
        end
        has_result = emit || i_item.last;
    end

    // Update decoder state; clear it after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_emit_cnt  <= '0;
            r_halted    <= 1'b0;
        end else if (o_pop) begin
            if (i_item.last) begin
                r_pend_bits <= '0;
                r_pend_cnt  <= '0;
                r_emit_cnt  <= '0;
                r_halted    <= 1'b0;
            end else begin
                r_pend_bits <= n_pend_bits;
                r_pend_cnt  <= n_pend_cnt;
                r_emit_cnt  <= n_emit_cnt;
                r_halted    <= n_halted;
            end
        end
    end

    // Hold the byte limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RESET;
        end else if (i_cfg_valid) begin
            r_max_bytes <= i_cfg_data;
        end
    end

    // Output register: load a new result or drop the taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && has_result) begin
            r_out_data   <= emit ? byte_val : '0;
            r_out_dvalid <= emit;
            r_out_done   <= i_item.last;
            r_out_count  <= n_emit_cnt;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_data       = r_out_data;
    assign o_data_valid = r_out_dvalid;
    assign o_done_res   = r_out_done;
    assign o_byte_count = r_out_count;
endmodule

// File: src/base32_stream_decoder_unit.sv
// Top level of the streaming base32 decoder.
// An accepted character is written into the queue, then decoded into the output register.
// Throughput: one character per cycle while neither the queue nor the output register stalls.
// A full queue or a stalled output register holds the input side off.
// Reset (synchronous, active low) clears the accumulator, counters, queue and output valid,
// and sets the byte limit to 65535.
module base32_stream_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = b32d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [b32d_pkg::CNT_W-1:0]  i_cfg_data,
    output logic                        o_cfg_ready,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [b32d_pkg::SYM_W-1:0]  i_symbol,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [b32d_pkg::BYTE_W-1:0] o_data,
    output logic                        o_data_valid,
    output logic                        o_done_res,
    output logic [b32d_pkg::CNT_W-1:0]  o_byte_count
);
    import b32d_pkg::*;

    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_valid;
    t_sym_item front_item;
    t_sym_item back_item;

    // Accept the limit register at any time
    assign o_cfg_ready = 1'b1;

    b32d_front u_front (
        .i_valid      (i_valid),
        .i_symbol     (i_symbol),
        .i_last       (i_last),
        .i_queue_full (queue_full),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_item       (front_item)
    );

    b32d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_item  (back_item)
    );

    b32d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (queue_valid),
        .i_item       (back_item),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_data       (o_data),
        .o_data_valid (o_data_valid),
        .o_done_res   (o_done_res),
        .o_byte_count (o_byte_count)
    );
endmodule

// File: src/b32d_checker.sv
// Port-level checker for the base32 stream decoder, bound to the top level.
`include "base32_stream_decoder_unit_macros.svh"

module b32d_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [b32d_pkg::BYTE_W-1:0] o_data,
    input logic                        o_data_valid,
    input logic                        o_done_res,
    input logic [b32d_pkg::CNT_W-1:0]  o_byte_count
);

    // A result without a byte carries zero data
    `B32D_ASSERT_SAME(a_nobyte_zero, i_clk, i_rst_n, o_valid && !o_data_valid, o_data == '0)

    // A result without a byte only ever ends a string
    `B32D_ASSERT_SAME(a_nobyte_done, i_clk, i_rst_n, o_valid && !o_data_valid, o_done_res)

    // A byte result always counts itself
    `B32D_ASSERT_SAME(a_byte_counted, i_clk, i_rst_n, o_valid && o_data_valid,
        o_byte_count != '0)

    // A stalled result holds
    `B32D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_data) && $stable(o_byte_count) && $stable(o_done_res))
endmodule

bind base32_stream_decoder_unit b32d_checker u_b32d_checker (.*);

// File: tb/tb_base32_stream_decoder_unit.sv
// Self-checking testbench for the streaming base32 decoder: directed cases, then random strings.
`timescale 1ns / 1ps

module tb_base32_stream_decoder_unit;

    typedef logic [b32d_pkg::SYM_W-1:0] sym_t;
    typedef logic [b32d_pkg::CNT_W-1:0] count_t;

    // One decoded result as it leaves the block
    typedef struct packed {
        logic [b32d_pkg::BYTE_W-1:0] data;
        logic                        data_valid;
        logic                        done;
        count_t                      byte_count;
    } decode_result_t;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    count_t                      i_cfg_data  = '0;
    logic                        o_cfg_ready;
    logic                        i_valid     = 1'b0;
    logic                        o_stall;
    sym_t                        i_symbol    = '0;
    logic                        i_last      = 1'b0;
    logic                        o_valid;
    logic                        i_stall     = 1'b0;
    logic [b32d_pkg::BYTE_W-1:0] o_data;
    logic                        o_data_valid;
    logic                        o_done_res;
    count_t                      o_byte_count;

    // Decoder state mirrored on the testbench side
    logic [b32d_pkg::PEND_W-1:0] acc_bits;
    logic [b32d_pkg::PCNT_W-1:0] acc_count;
    count_t                      bytes_out;
    logic                        nul_seen;
    count_t                      byte_limit;

    decode_result_t decoded_q[$];
    int             err_count      = 0;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;

    base32_stream_decoder_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_symbol     (i_symbol),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data),
        .o_data_valid (o_data_valid),
        .o_done_res   (o_done_res),
        .o_byte_count (o_byte_count)
    );

    // Run the 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Map one character to its five-bit value, zero outside the alphabet
    function automatic logic [b32d_pkg::VAL_W-1:0] char_to_bits(input sym_t c);
        if (c inside {[8'h61:8'h7A]}) return 5'(c - 8'h61);
        if (c inside {[8'h41:8'h5A]}) return 5'(c - 8'h41);
        if (c inside {[8'h30:8'h35]}) return 5'(c - 8'h30 + 8'd26);
        return '0;
    endfunction

    // Clear the per-string state
    function automatic void clear_string();
        acc_bits  = '0;
        acc_count = '0;
        bytes_out = '0;
        nul_seen  = 1'b0;
    endfunction

    // Advance the mirrored decoder by one character and queue any result it yields
    function automatic void decode_char(input sym_t sym, input logic is_last);
        logic [11:0]                 acc;
        logic [3:0]                  bits_held;
        logic [b32d_pkg::BYTE_W-1:0] out_byte;
        logic                        emit;
        out_byte = '0;
        emit     = 1'b0;
        if (!nul_seen && sym == b32d_pkg::SYM_NUL) nul_seen = 1'b1;
        if (!nul_seen) begin
            acc       = {acc_bits, char_to_bits(sym)};
            bits_held = 4'(acc_count) + 4'd5;
            if (bits_held >= 4'd8) begin
                bits_held = bits_held - 4'd8;
                if (bytes_out < byte_limit) begin
                    emit      = 1'b1;
                    out_byte  = 8'(acc >> bits_held);
                    bytes_out = bytes_out + 1'b1;
                end
            end
            acc_count = 3'(bits_held);
            acc_bits  = 7'(acc & ((12'd1 << bits_held) - 12'd1));
        end
        if (emit || is_last) decoded_q.push_back({out_byte, emit, is_last, bytes_out});
        if (is_last) clear_string();
    endfunction

    // Stall the output side at the current rate
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        decode_result_t got;
        decode_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_data, o_data_valid, o_done_res, o_byte_count};
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result data=%02h dv=%0b done=%0b count=%0d",
                         $time, got.data, got.data_valid, got.done, got.byte_count);
                err_count++;
            end else begin
                want = decoded_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch exp data=%02h dv=%0b done=%0b count=%0d",
                             $time, want.data, want.data_valid, want.done, want.byte_count);
                    $display("%0t:          got data=%02h dv=%0b done=%0b count=%0d",
                             $time, got.data, got.data_valid, got.done, got.byte_count);
                    err_count++;
                end
            end
        end
    end

    // Send one character, idling first at the current rate, and hold it until accepted
    task automatic send_char(input sym_t sym, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_symbol <= sym;
        i_last   <= is_last;
        do @(posedge i_clk); while (o_stall);
        decode_char(sym, is_last);
    endtask

    task automatic send_text(input string s, input logic close);
        for (int k = 0; k < s.len(); k++) send_char(sym_t'(s[k]), close && k == s.len() - 1);
    endtask

    // Drop valid and wait until every expected result has come out
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the byte limit once the decoder is idle
    task automatic write_limit(input count_t limit);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        byte_limit = limit;
    endtask

    // Cover both alphabets, the digit range and characters just outside each range
    task automatic test_alphabet();
        sym_t outside[8];
        outside = '{8'h60, 8'h7B, 8'h40, 8'h5B, 8'h2F, 8'h36, 8'h80, 8'hFF};
        send_text("azAZ05", 1'b0);
        for (int k = 0; k < 8; k++) send_char(outside[k], k == 7);
    endtask

    // Halt on a NUL mid-string, then end a string on a NUL alone
    task automatic test_nul();
        send_text("ab", 1'b0);
        send_char(b32d_pkg::SYM_NUL, 1'b0);
        send_text("cd", 1'b1);
        send_char(b32d_pkg::SYM_NUL, 1'b1);
    endtask

    // Suppress all bytes, then all but one
    task automatic test_limit_extremes();
        write_limit('0);
        send_text("abcd", 1'b1);
        write_limit(16'd1);
        send_text("abcd", 1'b1);
    endtask

    // Random strings: mostly clean alphabet text, some raw bytes, some cut short by a NUL
    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input count_t limit, input int n_chars);
        int   sent;
        int   len;
        int   kind;
        int   nul_at;
        int   idx;
        sym_t c;
        sent = 0;
        write_limit(limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < n_chars) begin
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
            kind   = $urandom_range(0, 99);
            nul_at = (kind >= 95) ? $urandom_range(0, len - 1) : -1;
            for (int k = 0; k < len; k++) begin
                if (kind >= 80 && kind < 95) begin
                    c = sym_t'($urandom_range(0, 255));
                end else if (k == nul_at) begin
                    c = b32d_pkg::SYM_NUL;
                end else begin
                    idx = $urandom_range(0, 31);
                    if (idx < 26) c = sym_t'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + idx);
                    else          c = sym_t'(8'h30 + idx - 26);
                end
                send_char(c, k == len - 1);
            end
            sent += len;
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Reset, run the directed cases, then the random phases
    initial begin
        clear_string();
        byte_limit = b32d_pkg::MAX_BYTES_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_alphabet();
        test_nul();
        test_limit_extremes();

        test_random_phase(0,  0,  16'hFFFF,                  205);
        test_random_phase(77, 0,  16'd0,                     205);
        test_random_phase(0,  77, 16'd1,                     205);
        test_random_phase(31, 31, count_t'($urandom_range(2, 6)), 205);
        test_random_phase(0,  0,  count_t'($urandom),        205);
        test_random_phase(77, 0,  count_t'($urandom_range(0, 3)), 205);
        test_random_phase(0,  77, 16'h7FFF,                  205);
        test_random_phase(31, 31, 16'hFFFF,                  205);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // End a hung run
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
